FILE: hdl/mwe_pkg.sv
package mwe_pkg;

	localparam int ADDR_BITS = 6;
	localparam int WORD_BITS = 16;

	// command frame: leading pad, start bit, opcode, address, data
	localparam int CMD_W = ADDR_BITS + 22;
	localparam int BC_W  = $clog2(CMD_W + 1);
	localparam int LIMIT_MAX = 1 << ADDR_BITS;
	localparam int LIMIT_W   = ADDR_BITS + 2;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic [1:0] K_RD_BYTE = 2'd0;
	localparam logic [1:0] K_WR_BYTE = 2'd1;
	localparam logic [1:0] K_RD_WORD = 2'd2;
	localparam logic [1:0] K_WR_WORD = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_VERIFY = 2'd2;
	localparam logic [1:0] ST_BUSY   = 2'd3;

	typedef struct packed {
		logic                 op;
		logic [1:0]           request_kind;
		logic [6:0]           offset;
		logic [WORD_BITS-1:0] write_data;
		logic                 data_out_sample;
	} req_t;

	typedef struct packed {
		logic                 chip_select;
		logic                 serial_clock;
		logic                 data_in_drive;
		logic                 busy_res;
		logic                 done_res;
		logic [WORD_BITS-1:0] read_data;
		logic [1:0]           status;
	} res_t;

endpackage

FILE: hdl/mwe_channels.sv
interface mwe_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [1:0]  request_kind;
	logic [6:0]  offset;
	logic [15:0] write_data;
	logic        data_out_sample;

	modport source (output valid, output op, output request_kind, output offset,
		output write_data, output data_out_sample, input ready);
	modport sink (input valid, input op, input request_kind, input offset,
		input write_data, input data_out_sample, output ready);
endinterface

interface mwe_res_if;
	logic        valid;
	logic        ready;
	logic        chip_select;
	logic        serial_clock;
	logic        data_in_drive;
	logic        busy_res;
	logic        done_res;
	logic [15:0] read_data;
	logic [1:0]  status;

	modport source (output valid, output chip_select, output serial_clock,
		output data_in_drive, output busy_res, output done_res, output read_data,
		output status, input ready);
	modport sink (input valid, input chip_select, input serial_clock,
		input data_in_drive, input busy_res, input done_res, input read_data,
		input status, output ready);
endinterface

interface mwe_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] words_in_use;

	modport source (output valid, output words_in_use, input ready);
	modport sink (input valid, input words_in_use, output ready);
endinterface

FILE: hdl/microwire_eeprom_controller_core.sv
// Microwire EEPROM master for 93C46-type parts with 16-bit words. Each request
// on req_ch is either a new request (read/write byte, read/write word) or a pin
// tick; every tick advances the pin pattern by one phase and its result carries
// the chip select, shift clock and data-in levels to drive for that phase,
// plus busy/done, read data and status. Exactly one result comes back per
// request, in the cycle after it is taken; one request is taken every clock as
// long as res_ch is drained, since the whole step is a single pass of logic
// between the controller state registers and the result register. Data-out
// is sampled from the tick that follows each clock-high phase. Word writes run
// enable, write, disable and a read-back verify; byte writes prepend a read and
// merge. words_in_use may only be written while no request is outstanding;
// word offsets (byte offset/2) at or above it, capped at 64 words, are refused.
module microwire_eeprom_controller_core (
	input  logic      clk,
	input  logic      arst_n,
	mwe_req_if.sink   req_ch,
	mwe_res_if.source res_ch,
	mwe_cfg_if.sink   cfg_ch
);
	import mwe_pkg::*;

	logic [6:0] words_in_use_q;
	logic       can_take;
	logic       fire;
	req_t       req;
	res_t       res;

	// config writes are always taken
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= 7'd12;
		end else if (cfg_ch.valid) begin
			words_in_use_q <= cfg_ch.words_in_use;
		end
	end

	// a new request is taken whenever the result slot is free or emptying
	assign req_ch.ready = can_take;
	assign fire         = req_ch.valid && can_take;

	assign req.op              = req_ch.op;
	assign req.request_kind    = req_ch.request_kind;
	assign req.offset          = req_ch.offset;
	assign req.write_data      = req_ch.write_data;
	assign req.data_out_sample = req_ch.data_out_sample;

	mwe_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.req          (req),
		.words_in_use (words_in_use_q),
		.res          (res)
	);

	mwe_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.res      (res),
		.can_take (can_take),
		.res_ch   (res_ch)
	);

endmodule

FILE: hdl/mwe_engine.sv
module mwe_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  mwe_pkg::req_t  req,
	input  logic [6:0]     words_in_use,
	output mwe_pkg::res_t  res
);
	import mwe_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_LOW   = 3'd2;
	localparam logic [2:0] PH_HIGH  = 3'd3;
	localparam logic [2:0] PH_END   = 3'd4;
	localparam logic [2:0] PH_DESEL = 3'd5;

	localparam logic [1:0] FR_READ  = 2'd0;
	localparam logic [1:0] FR_EWEN  = 2'd1;
	localparam logic [1:0] FR_WRITE = 2'd2;
	localparam logic [1:0] FR_EWDS  = 2'd3;

	logic [2:0]           phase_q, phase_n;
	logic [2:0]           frame_q, frame_n;
	logic [CMD_W-1:0]     cmd_q, cmd_n;
	logic [BC_W-1:0]      bc_q, bc_n;
	logic [WORD_BITS-1:0] rx_q, rx_n;
	logic                 pend_q, pend_n;
	logic [1:0]           kind_q, kind_n;
	logic [6:0]           off_q, off_n;
	logic [WORD_BITS-1:0] data_q, data_n;
	logic [WORD_BITS-1:0] merged_q, merged_n;

	logic [6:0]           woff_new, woff_cur;
	logic [LIMIT_W-1:0]   limit;
	logic [WORD_BITS-1:0] rx_v, merged_v;
	logic [BC_W-1:0]      idx;
	logic [CMD_W-1:0]     cmd_sh;
	logic [2:0]           frame_inc;
	logic [1:0]           ftype;

	function automatic logic [1:0] frame_of(input logic [1:0] kind, input logic [2:0] step);
		logic [2:0] s;
		s = step;
		if (kind == K_RD_BYTE || kind == K_RD_WORD) begin
			return FR_READ;
		end
		if (kind == K_WR_BYTE) begin
			if (step == 3'd0) begin
				return FR_READ;
			end
			s = step - 3'd1;
		end
		case (s[1:0])
			2'd0:    return FR_EWEN;
			2'd1:    return FR_WRITE;
			2'd2:    return FR_EWDS;
			default: return FR_READ;
		endcase
	endfunction

	function automatic logic [2:0] frame_count(input logic [1:0] kind);
		case (kind)
			K_WR_BYTE: return 3'd5;
			K_WR_WORD: return 3'd4;
			default:   return 3'd1;
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] build_cmd(input logic [1:0] ft,
		input logic [6:0] woff, input logic [WORD_BITS-1:0] word);
		logic [CMD_W-1:0] start;
		logic [CMD_W-1:0] addr;
		start = CMD_W'(1) << (ADDR_BITS + 18);
		addr  = CMD_W'(ADDR_BITS'(woff)) << WORD_BITS;
		case (ft)
			FR_READ:  return start | (CMD_W'(2) << (ADDR_BITS + 16)) | addr;
			FR_WRITE: return start | (CMD_W'(1) << (ADDR_BITS + 16)) | addr | CMD_W'(word);
			FR_EWEN:  return start | (CMD_W'(3) << (ADDR_BITS + 14));
			default:  return start;
		endcase
	endfunction

	function automatic logic [BC_W-1:0] frame_len(input logic [1:0] ft);
		return (ft == FR_READ) ? BC_W'(ADDR_BITS + 20) : BC_W'(CMD_W);
	endfunction

	assign woff_new = (req.request_kind == K_RD_BYTE || req.request_kind == K_WR_BYTE) ?
		{1'b0, req.offset[6:1]} : req.offset;
	assign woff_cur = (kind_q == K_RD_BYTE || kind_q == K_WR_BYTE) ?
		{1'b0, off_q[6:1]} : off_q;
	assign limit = ({1'b0, words_in_use} > LIMIT_W'(LIMIT_MAX)) ?
		LIMIT_W'(LIMIT_MAX) : LIMIT_W'(words_in_use);

	assign rx_v   = pend_q ? {rx_q[WORD_BITS-2:0], req.data_out_sample} : rx_q;
	assign idx    = bc_q - BC_W'(1);
	assign cmd_sh = cmd_q >> idx;
	assign frame_inc = frame_q + 3'd1;
	assign merged_v = (kind_q == K_WR_BYTE && frame_q == 3'd0) ?
		(off_q[0] ? {data_q[7:0], rx_v[7:0]} : {rx_v[15:8], data_q[7:0]}) : merged_q;

	always_comb begin
		phase_n  = phase_q;
		frame_n  = frame_q;
		cmd_n    = cmd_q;
		bc_n     = bc_q;
		rx_n     = rx_q;
		pend_n   = pend_q;
		kind_n   = kind_q;
		off_n    = off_q;
		data_n   = data_q;
		merged_n = merged_q;
		ftype    = FR_READ;
		res      = '0;
		if (req.op == OP_REQUEST) begin
			if (phase_q != PH_IDLE) begin
				res.busy_res = 1'b1;
				res.done_res = 1'b1;
				res.status   = ST_BUSY;
			end else if (LIMIT_W'(woff_new) >= limit) begin
				res.done_res = 1'b1;
				res.status   = ST_RANGE;
			end else begin
				kind_n   = req.request_kind;
				off_n    = req.offset;
				data_n   = req.write_data;
				merged_n = req.write_data;
				frame_n  = 3'd0;
				pend_n   = 1'b0;
				ftype    = frame_of(req.request_kind, 3'd0);
				cmd_n    = build_cmd(ftype, woff_new, req.write_data);
				bc_n     = frame_len(ftype);
				rx_n     = '0;
				phase_n  = PH_START;
				res.busy_res = 1'b1;
			end
		end else begin
			rx_n   = rx_v;
			pend_n = 1'b0;
			case (phase_q)
				PH_START: begin
					res.chip_select  = 1'b1;
					res.serial_clock = 1'b1;
					res.busy_res     = 1'b1;
					phase_n = (bc_q != '0) ? PH_LOW : PH_END;
				end
				PH_LOW: begin
					res.chip_select   = 1'b1;
					res.data_in_drive = cmd_sh[0];
					res.busy_res      = 1'b1;
					phase_n = PH_HIGH;
				end
				PH_HIGH: begin
					res.chip_select   = 1'b1;
					res.serial_clock  = 1'b1;
					res.data_in_drive = cmd_sh[0];
					res.busy_res      = 1'b1;
					pend_n  = 1'b1;
					bc_n    = bc_q - BC_W'(1);
					phase_n = (bc_q != BC_W'(1)) ? PH_LOW : PH_END;
				end
				PH_END: begin
					res.chip_select = 1'b1;
					res.busy_res    = 1'b1;
					phase_n = PH_DESEL;
				end
				PH_DESEL: begin
					merged_n = merged_v;
					if (frame_inc >= frame_count(kind_q)) begin
						phase_n = PH_IDLE;
						frame_n = 3'd0;
						res.done_res = 1'b1;
						if (kind_q == K_RD_BYTE) begin
							res.read_data = off_q[0] ? {8'd0, rx_v[15:8]} : {8'd0, rx_v[7:0]};
						end else begin
							res.read_data = rx_v;
							if (kind_q != K_RD_WORD && rx_v != merged_v) begin
								res.status = ST_VERIFY;
							end
						end
					end else begin
						frame_n = frame_inc;
						ftype   = frame_of(kind_q, frame_inc);
						cmd_n   = build_cmd(ftype, woff_cur, merged_v);
						bc_n    = frame_len(ftype);
						rx_n    = '0;
						phase_n = PH_START;
						res.busy_res = 1'b1;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			frame_q  <= '0;
			cmd_q    <= '0;
			bc_q     <= '0;
			rx_q     <= '0;
			pend_q   <= 1'b0;
			kind_q   <= '0;
			off_q    <= '0;
			data_q   <= '0;
			merged_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			frame_q  <= frame_n;
			cmd_q    <= cmd_n;
			bc_q     <= bc_n;
			rx_q     <= rx_n;
			pend_q   <= pend_n;
			kind_q   <= kind_n;
			off_q    <= off_n;
			data_q   <= data_n;
			merged_q <= merged_n;
		end
	end

endmodule

FILE: hdl/mwe_out_reg.sv
module mwe_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  mwe_pkg::res_t res,
	output logic          can_take,
	mwe_res_if.source     res_ch
);
	import mwe_pkg::*;

	logic valid_q;
	res_t data_q;

	// skid-free: a waiting result is replaced in the cycle it is taken
	assign can_take = !valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_q <= res;
		end
	end

	assign res_ch.valid         = valid_q;
	assign res_ch.chip_select   = data_q.chip_select;
	assign res_ch.serial_clock  = data_q.serial_clock;
	assign res_ch.data_in_drive = data_q.data_in_drive;
	assign res_ch.busy_res      = data_q.busy_res;
	assign res_ch.done_res      = data_q.done_res;
	assign res_ch.read_data     = data_q.read_data;
	assign res_ch.status        = data_q.status;

endmodule
